FILE: sv/gbcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcl_pkg
// Shared types, codes and defaults for the greedy ball cover landmark core.
// ----------------------------------------------------------------------------
package gbcl_pkg;

  localparam int unsigned MAX_LANDMARKS_DEF = 64;
  localparam int unsigned DIM_DEF           = 4;
  localparam int unsigned MAX_POINTS_DEF    = 65536;
  localparam int unsigned COORD_BITS_DEF    = 16;

  localparam int unsigned COORD_W      = 16;
  localparam int unsigned EPS_W        = 35;
  localparam int unsigned SQ_W         = 32;
  localparam int unsigned PT_IDX_W     = 16;
  localparam int unsigned LM_IDX_OUT_W = 6;
  localparam int unsigned LM_CNT_OUT_W = 7;
  localparam int unsigned MASK_W       = 64;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_SELECT = 2'd1,
    ACT_COVER  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e                    action;
    logic signed [COORD_W-1:0]  coord_0;
    logic signed [COORD_W-1:0]  coord_1;
    logic signed [COORD_W-1:0]  coord_2;
    logic signed [COORD_W-1:0]  coord_3;
  } in_item_t;

  typedef struct packed {
    logic [PT_IDX_W-1:0]     point_index;
    logic                    is_landmark;
    logic [LM_IDX_OUT_W-1:0] landmark_index;
    logic [LM_CNT_OUT_W-1:0] landmark_count;
    logic                    store_full;
    logic [MASK_W-1:0]       covered_mask;
    logic [LM_CNT_OUT_W-1:0] cover_count;
  } out_item_t;

endpackage

FILE: sv/gbcl_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcl_store
// Landmark memory: one write port, one registered read port tagged with
// its address and a valid flag.
// ----------------------------------------------------------------------------
module gbcl_store
  import gbcl_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_LANDMARKS_DEF,
  parameter int unsigned WIDTH = DIM_DEF * COORD_W,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic             rd_vld_o,
  output logic [AW-1:0]    rd_idx_o,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;
  logic [AW-1:0]    rd_idx_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= mem[raddr_i];
    end
    rd_idx_q <= raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= re_i;
    end
  end

  assign rd_vld_o  = rd_vld_q;
  assign rd_idx_o  = rd_idx_q;
  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/gbcl_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcl_dist
// Three-stage squared distance unit: lane squares, sum, compare to epsilon.
// ----------------------------------------------------------------------------
module gbcl_dist
  import gbcl_pkg::*;
#(
  parameter int unsigned DIM  = DIM_DEF,
  parameter int unsigned IDXW = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic [IDXW-1:0]        idx_i,
  input  logic [DIM*COORD_W-1:0] point_i,
  input  logic [DIM*COORD_W-1:0] lm_i,
  input  logic [EPS_W-1:0]       eps_i,
  output logic                   hit_vld_o,
  output logic [IDXW-1:0]        hit_idx_o,
  output logic                   hit_o
);

  logic [SQ_W-1:0]  sq_d [DIM];
  logic [SQ_W-1:0]  sq_q [DIM];
  logic [EPS_W-1:0] sum_d;
  logic [EPS_W-1:0] sum_q;
  logic             hit_q;
  logic             v1_q, v2_q, v3_q;
  logic [IDXW-1:0]  idx1_q, idx2_q, idx3_q;

  always_comb begin
    logic signed [COORD_W:0]     diff;
    logic signed [2*COORD_W+1:0] prod;
    for (int i = 0; i < DIM; i++) begin
      diff    = {point_i[i*COORD_W+COORD_W-1], point_i[i*COORD_W +: COORD_W]}
              - {lm_i[i*COORD_W+COORD_W-1], lm_i[i*COORD_W +: COORD_W]};
      prod    = diff * diff;
      sq_d[i] = prod[SQ_W-1:0];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < DIM; i++) begin
      sum_d = sum_d + EPS_W'(sq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    sum_q  <= sum_d;
    hit_q  <= (sum_q <= eps_i);
    idx1_q <= idx_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign hit_vld_o = v3_q;
  assign hit_idx_o = idx3_q;
  assign hit_o     = hit_q;

endmodule

FILE: sv/gbcl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcl_ctrl
// Sequencer: takes one item, scans the stored landmarks, gathers hits,
// updates counters and the store, and holds the result beat.
// ----------------------------------------------------------------------------
module gbcl_ctrl
  import gbcl_pkg::*;
#(
  parameter int unsigned MAX_LANDMARKS = MAX_LANDMARKS_DEF,
  parameter int unsigned DIM           = DIM_DEF,
  parameter int unsigned MAX_POINTS    = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
  localparam int unsigned IDXW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1,
  localparam int unsigned CNTW = $clog2(MAX_LANDMARKS + 1),
  localparam int unsigned PW   = DIM * COORD_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o,
  output logic            we_o,
  output logic [IDXW-1:0] waddr_o,
  output logic [PW-1:0]   wdata_o,
  output logic            re_o,
  output logic [IDXW-1:0] raddr_o,
  output logic [PW-1:0]   point_o,
  input  logic            hit_vld_i,
  input  logic [IDXW-1:0] hit_idx_i,
  input  logic            hit_i
);

  localparam int unsigned SH = COORD_W - COORD_BITS;
  localparam logic [PT_IDX_W-1:0] PT_LAST = PT_IDX_W'(MAX_POINTS - 1);
  localparam logic [CNTW-1:0]     LM_MAX  = CNTW'(MAX_LANDMARKS);

  state_e                state_q, state_d;
  action_e               act_q, act_d;
  logic [PW-1:0]         pt_q, pt_d;
  logic [IDXW-1:0]       iss_q, iss_d;
  logic [MAX_LANDMARKS-1:0] mask_q, mask_d;
  logic [CNTW-1:0]       hits_q, hits_d;
  logic [CNTW-1:0]       total_q, total_d;
  logic [PT_IDX_W-1:0]   sel_cnt_q, sel_cnt_d;
  logic [PT_IDX_W-1:0]   cov_cnt_q, cov_cnt_d;
  out_item_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic                  accept;
  logic [IDXW-1:0]       last_idx;
  logic [3:0][COORD_W-1:0] coords;

  assign coords   = {in_item_i.coord_3, in_item_i.coord_2,
                     in_item_i.coord_1, in_item_i.coord_0};
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign last_idx = IDXW'(total_q - 1'b1);

  always_comb begin
    logic [COORD_W-1:0] shl;
    for (int i = 0; i < DIM; i++) begin
      shl                     = coords[i] << SH;
      pt_d[i*COORD_W +: COORD_W] = COORD_W'($signed(shl) >>> SH);
    end
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    iss_d       = iss_q;
    mask_d      = mask_q;
    hits_d      = hits_q;
    total_d     = total_q;
    sel_cnt_d   = sel_cnt_q;
    cov_cnt_d   = cov_cnt_q;
    out_d       = out_q;
    out_load    = 1'b0;
    we_o        = 1'b0;
    waddr_o     = total_q[IDXW-1:0];
    re_o        = 1'b0;
    raddr_o     = iss_q;

    if (hit_vld_i && hit_i) begin
      mask_d[hit_idx_i] = 1'b1;
      hits_d            = hits_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d  = in_item_i.action;
          iss_d  = '0;
          mask_d = '0;
          hits_d = '0;
          if ((in_item_i.action == ACT_SELECT || in_item_i.action == ACT_COVER)
              && total_q != '0) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        re_o  = 1'b1;
        iss_d = iss_q + 1'b1;
        if (iss_q == last_idx) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (hit_vld_i && hit_idx_i == last_idx) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          out_d    = '0;
          case (act_q)
            ACT_CLEAR: begin
              total_d   = '0;
              sel_cnt_d = '0;
              cov_cnt_d = '0;
            end
            ACT_SELECT: begin
              out_d.point_index = sel_cnt_q;
              sel_cnt_d = (sel_cnt_q == PT_LAST) ? '0 : sel_cnt_q + 1'b1;
              if (hits_q == '0) begin
                if (total_q < LM_MAX) begin
                  we_o                 = 1'b1;
                  out_d.is_landmark    = 1'b1;
                  out_d.landmark_index = LM_IDX_OUT_W'(total_q);
                  total_d              = total_q + 1'b1;
                end else begin
                  out_d.store_full = 1'b1;
                end
              end
              out_d.landmark_count = LM_CNT_OUT_W'(total_d);
            end
            ACT_COVER: begin
              out_d.point_index    = cov_cnt_q;
              cov_cnt_d = (cov_cnt_q == PT_LAST) ? '0 : cov_cnt_q + 1'b1;
              out_d.landmark_count = LM_CNT_OUT_W'(total_q);
              out_d.covered_mask   = MASK_W'(mask_q);
              out_d.cover_count    = LM_CNT_OUT_W'(hits_q);
            end
            default: begin
              out_d.landmark_count = LM_CNT_OUT_W'(total_q);
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      sel_cnt_q   <= '0;
      cov_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      sel_cnt_q   <= sel_cnt_d;
      cov_cnt_q   <= cov_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    iss_q  <= iss_d;
    mask_q <= mask_d;
    hits_q <= hits_d;
    out_q  <= out_d;
    if (accept) begin
      pt_q <= pt_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign wdata_o     = pt_q;
  assign point_o     = pt_q;

endmodule

FILE: sv/greedy_ball_cover_landmarks_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_ball_cover_landmarks_core
// Clear and undefined items, and any item while the store is empty, go
// straight to their result beat after accept; selection and coverage items
// first scan the N stored landmarks, with one memory read per landmark.
// Only one item is in flight: the next is taken once the result beat is
// loaded, and a stalled result beat holds the next item before output.
// Reset: counters and epsilon clear at once; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module greedy_ball_cover_landmarks_core
  import gbcl_pkg::*;
#(
  parameter int unsigned MAX_LANDMARKS = MAX_LANDMARKS_DEF,
  parameter int unsigned DIM           = DIM_DEF,
  parameter int unsigned MAX_POINTS    = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [EPS_W-1:0] cfg_data_i
);

  localparam int unsigned IDXW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int unsigned PW   = DIM * COORD_W;

  logic [EPS_W-1:0] eps_q;
  logic             we;
  logic [IDXW-1:0]  waddr;
  logic [PW-1:0]    wdata;
  logic             re;
  logic [IDXW-1:0]  raddr;
  logic [PW-1:0]    point;
  logic             rd_vld;
  logic [IDXW-1:0]  rd_idx;
  logic [PW-1:0]    rd_data;
  logic             hit_vld;
  logic [IDXW-1:0]  hit_idx;
  logic             hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      eps_q <= cfg_data_i;
    end
  end

  gbcl_ctrl #(
    .MAX_LANDMARKS (MAX_LANDMARKS),
    .DIM           (DIM),
    .MAX_POINTS    (MAX_POINTS),
    .COORD_BITS    (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .point_o     (point),
    .hit_vld_i   (hit_vld),
    .hit_idx_i   (hit_idx),
    .hit_i       (hit)
  );

  gbcl_store #(
    .DEPTH (MAX_LANDMARKS),
    .WIDTH (PW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (re),
    .raddr_i   (raddr),
    .rd_vld_o  (rd_vld),
    .rd_idx_o  (rd_idx),
    .rd_data_o (rd_data)
  );

  gbcl_dist #(
    .DIM  (DIM),
    .IDXW (IDXW)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (rd_vld),
    .idx_i     (rd_idx),
    .point_i   (point),
    .lm_i      (rd_data),
    .eps_i     (eps_q),
    .hit_vld_o (hit_vld),
    .hit_idx_o (hit_idx),
    .hit_o     (hit)
  );

endmodule

FILE: sv/gbcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcl_checker
// Port-level checks on the landmark core's handshakes and result beats.
// ----------------------------------------------------------------------------
module gbcl_checker
  import gbcl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again before item finished");

  a_mask_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(out_item_o.covered_mask) == out_item_o.cover_count))
    else $error("cover count disagrees with mask");

  a_new_landmark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.is_landmark) |->
      (!out_item_o.store_full &&
       out_item_o.landmark_count == LM_CNT_OUT_W'(out_item_o.landmark_index) + 1'b1))
    else $error("new landmark beat inconsistent");

  a_full_no_landmark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.store_full) |-> (out_item_o.covered_mask == '0))
    else $error("full flag on a coverage beat");

endmodule

bind greedy_ball_cover_landmarks_core gbcl_checker u_gbcl_checker (.*);
